// ===== rtl/rvalu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rvalu_pkg;

    localparam int XLEN = 64;
    localparam int HALF = 32;
    localparam int IMM_W = 12;
    localparam int OP_W = 5;
    localparam int SHAMT_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 5'd0,
        OP_ADDI  = 5'd1,
        OP_ADDIW = 5'd2,
        OP_ADDW  = 5'd3,
        OP_LUI   = 5'd4,
        OP_MUL   = 5'd5,
        OP_MULW  = 5'd6,
        OP_MULH  = 5'd7,
        OP_SLTU  = 5'd8,
        OP_SLLIW = 5'd9,
        OP_SLLI  = 5'd10,
        OP_SLT   = 5'd11,
        OP_SRLI  = 5'd12,
        OP_SUB   = 5'd13,
        OP_SUBW  = 5'd14,
        OP_ANDI  = 5'd15,
        OP_ORI   = 5'd16,
        OP_XORI  = 5'd17,
        OP_OR    = 5'd18
    } rvalu_op_t;

    typedef struct packed {
        logic [OP_W-1:0]         action;
        logic [XLEN-1:0]         src_a;
        logic [XLEN-1:0]         src_b;
        logic signed [IMM_W-1:0] imm_i;
        logic [XLEN-1:0]         imm_u;
    } rvalu_in_t;

    typedef struct packed {
        logic [XLEN-1:0] result;
        logic            unsupported;
    } rvalu_out_t;

    // per-stage advance strobes for the multiplier pipeline
    typedef struct packed {
        logic s2;
        logic s3;
    } rvalu_adv_t;

endpackage

`default_nettype wire

// ===== rtl/rvalu_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rvalu_mul import rvalu_pkg::*; (
    input  wire logic            aclk,
    input  wire rvalu_adv_t      adv,
    input  wire logic [XLEN-1:0] a_i,
    input  wire logic [XLEN-1:0] b_i,
    output logic [XLEN-1:0]      mul_lo,
    output logic [XLEN-1:0]      mul_hs
);

    logic [XLEN-1:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic [XLEN-1:0]   fix_reg;
    logic [XLEN-1:0]   fix3_reg;
    logic [XLEN-1:0]   lo_reg;
    logic [XLEN-1:0]   hip_reg;
    logic [1:0]        carry_reg;

    logic [XLEN-1:0]   fix_next;
    logic [HALF+1:0]   mid;
    logic [XLEN-1:0]   hip_next;

    // signed high product correction
    always_comb begin
        fix_next = (a_i[XLEN-1] ? b_i : '0) + (b_i[XLEN-1] ? a_i : '0);
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            p00_reg <= a_i[HALF-1:0] * b_i[HALF-1:0];
            p01_reg <= a_i[HALF-1:0] * b_i[XLEN-1:HALF];
            p10_reg <= a_i[XLEN-1:HALF] * b_i[HALF-1:0];
            p11_reg <= a_i[XLEN-1:HALF] * b_i[XLEN-1:HALF];
            fix_reg <= fix_next;
        end
    end

    always_comb begin
        mid = {2'b00, p00_reg[XLEN-1:HALF]} + {2'b00, p01_reg[HALF-1:0]}
            + {2'b00, p10_reg[HALF-1:0]};
        hip_next = p11_reg + {{HALF{1'b0}}, p01_reg[XLEN-1:HALF]}
                 + {{HALF{1'b0}}, p10_reg[XLEN-1:HALF]};
    end

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            lo_reg    <= {mid[HALF-1:0], p00_reg[HALF-1:0]};
            carry_reg <= mid[HALF+1:HALF];
            hip_reg   <= hip_next;
            fix3_reg  <= fix_reg;
        end
    end

    assign mul_lo = lo_reg;
    assign mul_hs = hip_reg + {{(XLEN-2){1'b0}}, carry_reg} - fix3_reg;

endmodule

`default_nettype wire

// ===== rtl/rv64_integer_alu.sv =====
// rv64_integer_alu: RV64 integer ALU, one operation per item, no state between items.
// Input channel s_valid / s_ready / s_data carries the opcode, two 64-bit source
// operands, the 12-bit I-immediate and the ready-formed U-immediate.
// Result channel m_valid / m_ready / m_data carries the 64-bit result and an
// unsupported flag (result 0) for opcodes 19 to 31.
// Four register stages: input capture, 32x32 partial products and the plain ALU,
// partial-product combine, and signed-high fix-up with result select; m_valid is
// the valid bit of the last stage, and the result is taken while m_ready is high.
// Throughput: one item per cycle unless the output stalls; the four 32x32 multipliers are fully pipelined.
// Reset (aresetn low, synchronous) clears all stage valid bits; items in flight
// are dropped and m_valid is low after reset.
// When m_ready is low the output holds; stages behind it keep filling empty slots,
// and s_ready drops only when every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none

module rv64_integer_alu import rvalu_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire rvalu_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output rvalu_out_t      m_data
);

    function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] x);
        return {{HALF{x[HALF-1]}}, x[HALF-1:0]};
    endfunction

    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    rvalu_in_t       s1_data_reg;
    logic [OP_W-1:0] s2_op_reg, s3_op_reg;
    logic [XLEN-1:0] s2_res_reg, s3_res_reg;
    logic            s2_bad_reg, s3_bad_reg;
    rvalu_out_t      m_data_reg;

    logic            rdy1, rdy2, rdy3, rdy4;
    rvalu_adv_t      adv;
    logic [XLEN-1:0] a, b, imm64, sum_imm, sum_ab, diff_ab, shl;
    logic [SHAMT_W-1:0] sh;
    logic [XLEN-1:0] s2_res_next;
    logic            s2_bad_next;
    logic [XLEN-1:0] mul_lo, mul_hs;
    rvalu_out_t      m_data_next;

    // stage handshake
    assign rdy4 = !m_valid_reg || m_ready;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;
    assign s_ready = rdy1;
    assign adv.s2 = rdy2 && s1_valid_reg;
    assign adv.s3 = rdy3 && s2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (rdy1) begin
                s1_valid_reg <= s_valid;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4) begin
                m_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            s1_data_reg <= s_data;
        end
    end

    // plain alu ops
    always_comb begin
        a       = s1_data_reg.src_a;
        b       = s1_data_reg.src_b;
        imm64   = {{(XLEN-IMM_W){s1_data_reg.imm_i[IMM_W-1]}}, s1_data_reg.imm_i};
        sh      = s1_data_reg.imm_i[SHAMT_W-1:0];
        sum_imm = a + imm64;
        sum_ab  = a + b;
        diff_ab = a - b;
        shl     = a << sh;
        s2_bad_next = 1'b0;
        case (rvalu_op_t'(s1_data_reg.action))
            OP_ADD:   s2_res_next = sum_ab;
            OP_ADDI:  s2_res_next = sum_imm;
            OP_ADDIW: s2_res_next = sext32(sum_imm);
            OP_ADDW:  s2_res_next = sext32(sum_ab);
            OP_LUI:   s2_res_next = s1_data_reg.imm_u;
            OP_MUL:   s2_res_next = '0;
            OP_MULW:  s2_res_next = '0;
            OP_MULH:  s2_res_next = '0;
            OP_SLTU:  s2_res_next = {{(XLEN-1){1'b0}}, a < b};
            OP_SLLIW: s2_res_next = sext32(shl);
            OP_SLLI:  s2_res_next = shl;
            OP_SLT:   s2_res_next = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
            OP_SRLI:  s2_res_next = a >> sh;
            OP_SUB:   s2_res_next = diff_ab;
            OP_SUBW:  s2_res_next = sext32(diff_ab);
            OP_ANDI:  s2_res_next = a & imm64;
            OP_ORI:   s2_res_next = a | imm64;
            OP_XORI:  s2_res_next = a ^ imm64;
            OP_OR:    s2_res_next = a | b;
            default: begin
                s2_res_next = '0;
                s2_bad_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            s2_op_reg  <= s1_data_reg.action;
            s2_res_reg <= s2_res_next;
            s2_bad_reg <= s2_bad_next;
        end
        if (adv.s3) begin
            s3_op_reg  <= s2_op_reg;
            s3_res_reg <= s2_res_reg;
            s3_bad_reg <= s2_bad_reg;
        end
    end

    rvalu_mul u_mul (
        .aclk   (aclk),
        .adv    (adv),
        .a_i    (s1_data_reg.src_a),
        .b_i    (s1_data_reg.src_b),
        .mul_lo (mul_lo),
        .mul_hs (mul_hs)
    );

    // final select
    always_comb begin
        m_data_next.unsupported = s3_bad_reg;
        case (rvalu_op_t'(s3_op_reg))
            OP_MUL:  m_data_next.result = mul_lo;
            OP_MULW: m_data_next.result = sext32(mul_lo);
            OP_MULH: m_data_next.result = mul_hs;
            default: m_data_next.result = s3_res_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && s3_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
